// File: design/pts_pkg.sv
// Shared types, token codes and character classes of the Pascal token scanner.
// No dependencies; pts_scan, pts_outq and the top level refer to it by scoped names.
`default_nettype none
package pts_pkg;

  localparam int unsigned GRP_SLOTS = 4;
  localparam int unsigned GRP_DEPTH = 4;

  localparam logic [7:0] BOM_B0    = 8'hEF;
  localparam logic [7:0] BOM_B1    = 8'hBB;
  localparam logic [7:0] BOM_B2    = 8'hBF;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;

  localparam logic [4:0] K_STAR   = 5'd0;
  localparam logic [4:0] K_AT     = 5'd1;
  localparam logic [4:0] K_CARET  = 5'd2;
  localparam logic [4:0] K_ASSIGN = 5'd3;
  localparam logic [4:0] K_COLON  = 5'd4;
  localparam logic [4:0] K_COMMA  = 5'd5;
  localparam logic [4:0] K_DOLLAR = 5'd6;
  localparam logic [4:0] K_DOTDOT = 5'd7;
  localparam logic [4:0] K_DOT    = 5'd8;
  localparam logic [4:0] K_EQUAL  = 5'd9;
  localparam logic [4:0] K_GT     = 5'd10;
  localparam logic [4:0] K_LBRACK = 5'd11;
  localparam logic [4:0] K_LT     = 5'd12;
  localparam logic [4:0] K_LPAREN = 5'd13;
  localparam logic [4:0] K_MINUS  = 5'd14;
  localparam logic [4:0] K_PLUS   = 5'd15;
  localparam logic [4:0] K_RBRACK = 5'd16;
  localparam logic [4:0] K_RPAREN = 5'd17;
  localparam logic [4:0] K_SEMI   = 5'd18;
  localparam logic [4:0] K_SLASH  = 5'd19;
  localparam logic [4:0] K_NUMBER = 5'd20;
  localparam logic [4:0] K_IDENT  = 5'd21;
  localparam logic [4:0] K_STRING = 5'd22;
  localparam logic [4:0] K_END    = 5'd23;

  typedef enum logic [17:0] {
    M_START    = 18'h00001,
    M_IDLE     = 18'h00002,
    M_BRACE    = 18'h00004,
    M_PAREN    = 18'h00008,
    M_PSTAR    = 18'h00010,
    M_LINE     = 18'h00020,
    M_COLON    = 18'h00040,
    M_DOT      = 18'h00080,
    M_LPAR     = 18'h00100,
    M_SLASH    = 18'h00200,
    M_NUM      = 18'h00400,
    M_NUM_DOT  = 18'h00800,
    M_NUM_E    = 18'h01000,
    M_NUM_SIGN = 18'h02000,
    M_IDENT    = 18'h04000,
    M_STR_Q    = 18'h08000,
    M_STR_H    = 18'h10000,
    M_STR_GAP  = 18'h20000
  } mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        final_token;
  } out_item_t;

  typedef struct packed {
    logic [2:0]                     cnt;
    out_item_t [GRP_SLOTS-1:0]      tok;
  } group_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) || (b == 8'h5F);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  // {hit, kind} for the one-byte punctuation tokens
  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] r;
    case (b)
      8'h2A:   r = {1'b1, K_STAR};
      8'h40:   r = {1'b1, K_AT};
      8'h5E:   r = {1'b1, K_CARET};
      8'h2C:   r = {1'b1, K_COMMA};
      8'h24:   r = {1'b1, K_DOLLAR};
      8'h3D:   r = {1'b1, K_EQUAL};
      8'h3E:   r = {1'b1, K_GT};
      8'h5B:   r = {1'b1, K_LBRACK};
      8'h3C:   r = {1'b1, K_LT};
      8'h2D:   r = {1'b1, K_MINUS};
      8'h2B:   r = {1'b1, K_PLUS};
      8'h5D:   r = {1'b1, K_RBRACK};
      8'h29:   r = {1'b1, K_RPAREN};
      8'h3B:   r = {1'b1, K_SEMI};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] bom_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = BOM_B0;
      2'd1:    r = BOM_B1;
      default: r = BOM_B2;
    endcase
    return r;
  endfunction

  // saturating length add
  function automatic logic [15:0] grow(input logic [15:0] s, input logic [1:0] n);
    logic [16:0] t;
    t = {1'b0, s} + {15'd0, n};
    return t[16] ? 16'hFFFF : t[15:0];
  endfunction

  function automatic out_item_t mk_tok(input logic [4:0] k, input logic [15:0] st,
                                       input logic [15:0] len, input logic fin);
    out_item_t r;
    r.token_kind   = k;
    r.token_start  = st;
    r.token_length = len;
    r.final_token  = fin;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/pts_chan_if.sv
// Valid/ready channel carrying one payload item per transaction.
// Payload type comes in as a type parameter, usually from pts_pkg.
`default_nettype none
interface pts_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/pts_scan.sv
// Scanner state registers and the one-byte step that yields up to four tokens.
// Depends on pts_pkg for modes, token codes and character classes.
`default_nettype none
module pts_scan #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire pts_pkg::in_item_t item,
  output pts_pkg::group_t        grp
);

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned NSLOT = 9;

  pts_pkg::mode_t  mode_r, mode_nxt, m;
  logic [PB-1:0]   pos_r, pos_nxt, org_r, org_nxt, org, nextp;
  logic [15:0]     span_r, span_nxt, sp;
  logic [1:0]      phase_r, phase_nxt, ph;
  logic [1:0]      la_cnt_r, la_cnt_nxt, cnt;
  logic            sign_r, sign_nxt, sg;
  logic            halted_r, halted_nxt, hlt;
  logic            closed, consumed, cont, last;
  logic [7:0]      b;
  logic [5:0]      sk;
  logic [NSLOT-1:0] slot_v;
  pts_pkg::out_item_t slot_tok [NSLOT];
  logic [3:0]      n;

  function automatic logic [15:0] lo16(input logic [PB-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[15:0];
  endfunction

  always_comb begin
    b     = item.char_byte;
    last  = item.stream_end;
    nextp = pos_r + PB'(1);
    m     = mode_r;
    org   = org_r;
    sp    = span_r;
    ph    = phase_r;
    cnt   = la_cnt_r;
    sg    = sign_r;
    hlt   = halted_r;
    closed   = 1'b0;
    consumed = 1'b0;
    cont     = 1'b0;
    sk       = pts_pkg::single_kind(b);
    slot_v   = '0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_tok[i] = '0;
    end

    // resolve held lookahead before the byte itself
    if (hlt) begin
      consumed = 1'b1;
    end else if (m == pts_pkg::M_START) begin
      consumed = 1'b1;
      if (b == pts_pkg::bom_byte(cnt)) begin
        if (cnt == 2'd2) begin
          cnt = 2'd0;
          m   = pts_pkg::M_IDLE;
        end else begin
          cnt = cnt + 2'd1;
        end
      end else begin
        m = pts_pkg::M_IDLE;
        if (cnt != 2'd0) begin
          slot_v[1]   = 1'b1;
          slot_tok[1] = pts_pkg::mk_tok(pts_pkg::K_END, lo16(pos_r - PB'(cnt)), 16'd0, last);
          hlt    = 1'b1;
          closed = last;
          cnt    = 2'd0;
        end else begin
          consumed = 1'b0;
        end
      end
    end else if (m == pts_pkg::M_NUM_DOT) begin
      if (pts_pkg::is_digit(b)) begin
        sp = pts_pkg::grow(sp, 2'd2);
        ph = 2'd1;
        m  = pts_pkg::M_NUM;
        consumed = 1'b1;
      end else begin
        slot_v[0]   = 1'b1;
        slot_tok[0] = pts_pkg::mk_tok(pts_pkg::K_NUMBER, lo16(org), sp, 1'b0);
        m   = pts_pkg::M_DOT;
        org = pos_r - PB'(1);
        sp  = 16'd1;
      end
    end else if (m == pts_pkg::M_NUM_E) begin
      if (pts_pkg::is_digit(b)) begin
        sp = pts_pkg::grow(sp, 2'd2);
        ph = 2'd2;
        m  = pts_pkg::M_NUM;
        consumed = 1'b1;
      end else if (b == pts_pkg::CH_PLUS || b == pts_pkg::CH_MINUS) begin
        sg = (b == pts_pkg::CH_MINUS);
        m  = pts_pkg::M_NUM_SIGN;
        consumed = 1'b1;
      end else begin
        slot_v[0]   = 1'b1;
        slot_tok[0] = pts_pkg::mk_tok(pts_pkg::K_NUMBER, lo16(org), sp, 1'b0);
        m   = pts_pkg::M_IDENT;
        org = pos_r - PB'(1);
        sp  = 16'd1;
      end
    end else if (m == pts_pkg::M_NUM_SIGN) begin
      if (pts_pkg::is_digit(b)) begin
        sp = pts_pkg::grow(sp, 2'd3);
        ph = 2'd2;
        m  = pts_pkg::M_NUM;
        consumed = 1'b1;
      end else begin
        slot_v[2:0] = 3'b111;
        slot_tok[0] = pts_pkg::mk_tok(pts_pkg::K_NUMBER, lo16(org), sp, 1'b0);
        slot_tok[1] = pts_pkg::mk_tok(pts_pkg::K_IDENT, lo16(pos_r - PB'(2)), 16'd1, 1'b0);
        slot_tok[2] = pts_pkg::mk_tok(sg ? pts_pkg::K_MINUS : pts_pkg::K_PLUS,
                                      lo16(pos_r - PB'(1)), 16'd1, 1'b0);
        m = pts_pkg::M_IDLE;
      end
    end

    // the byte in the current mode
    if (!consumed) begin
      unique case (m)
        pts_pkg::M_IDLE: cont = 1'b1;
        pts_pkg::M_BRACE: begin
          if (b == pts_pkg::CH_RBRACE) m = pts_pkg::M_IDLE;
        end
        pts_pkg::M_PAREN: begin
          if (b == pts_pkg::CH_STAR) m = pts_pkg::M_PSTAR;
        end
        pts_pkg::M_PSTAR: begin
          if (b == pts_pkg::CH_RPAREN) m = pts_pkg::M_IDLE;
          else if (b != pts_pkg::CH_STAR) m = pts_pkg::M_PAREN;
        end
        pts_pkg::M_LINE: begin
          if (b == pts_pkg::CH_LF) m = pts_pkg::M_IDLE;
        end
        pts_pkg::M_COLON: begin
          m = pts_pkg::M_IDLE;
          slot_v[3] = 1'b1;
          if (b == pts_pkg::CH_EQUAL) begin
            slot_tok[3] = pts_pkg::mk_tok(pts_pkg::K_ASSIGN, lo16(org), 16'd2, 1'b0);
          end else begin
            slot_tok[3] = pts_pkg::mk_tok(pts_pkg::K_COLON, lo16(org), 16'd1, 1'b0);
            cont = 1'b1;
          end
        end
        pts_pkg::M_DOT: begin
          m = pts_pkg::M_IDLE;
          slot_v[3] = 1'b1;
          if (b == pts_pkg::CH_DOT) begin
            slot_tok[3] = pts_pkg::mk_tok(pts_pkg::K_DOTDOT, lo16(org), 16'd2, 1'b0);
          end else begin
            slot_tok[3] = pts_pkg::mk_tok(pts_pkg::K_DOT, lo16(org), 16'd1, 1'b0);
            cont = 1'b1;
          end
        end
        pts_pkg::M_LPAR: begin
          if (b == pts_pkg::CH_STAR) begin
            m = pts_pkg::M_PAREN;
          end else begin
            m = pts_pkg::M_IDLE;
            slot_v[3]   = 1'b1;
            slot_tok[3] = pts_pkg::mk_tok(pts_pkg::K_LPAREN, lo16(org), 16'd1, 1'b0);
            cont = 1'b1;
          end
        end
        pts_pkg::M_SLASH: begin
          if (b == pts_pkg::CH_SLASH) begin
            m = pts_pkg::M_LINE;
          end else begin
            m = pts_pkg::M_IDLE;
            slot_v[3]   = 1'b1;
            slot_tok[3] = pts_pkg::mk_tok(pts_pkg::K_SLASH, lo16(org), 16'd1, 1'b0);
            cont = 1'b1;
          end
        end
        pts_pkg::M_NUM: begin
          if (pts_pkg::is_digit(b)) begin
            sp = pts_pkg::grow(sp, 2'd1);
          end else if (b == pts_pkg::CH_DOT && ph == 2'd0) begin
            m = pts_pkg::M_NUM_DOT;
          end else if ((b == pts_pkg::CH_LOW_E || b == pts_pkg::CH_UP_E) && ph != 2'd2) begin
            m = pts_pkg::M_NUM_E;
          end else begin
            m = pts_pkg::M_IDLE;
            slot_v[3]   = 1'b1;
            slot_tok[3] = pts_pkg::mk_tok(pts_pkg::K_NUMBER, lo16(org), sp, 1'b0);
            cont = 1'b1;
          end
        end
        pts_pkg::M_IDENT: begin
          if (pts_pkg::is_alpha(b) || pts_pkg::is_digit(b)) begin
            sp = pts_pkg::grow(sp, 2'd1);
          end else begin
            m = pts_pkg::M_IDLE;
            slot_v[3]   = 1'b1;
            slot_tok[3] = pts_pkg::mk_tok(pts_pkg::K_IDENT, lo16(org), sp, 1'b0);
            cont = 1'b1;
          end
        end
        pts_pkg::M_STR_Q: begin
          sp = pts_pkg::grow(sp, 2'd1);
          if (b == pts_pkg::CH_QUOTE) m = pts_pkg::M_STR_GAP;
        end
        pts_pkg::M_STR_H, pts_pkg::M_STR_GAP: begin
          if (m == pts_pkg::M_STR_H && pts_pkg::is_digit(b)) begin
            sp = pts_pkg::grow(sp, 2'd1);
          end else if (b == pts_pkg::CH_QUOTE) begin
            sp = pts_pkg::grow(sp, 2'd1);
            m  = pts_pkg::M_STR_Q;
          end else if (b == pts_pkg::CH_HASH) begin
            sp = pts_pkg::grow(sp, 2'd1);
            m  = pts_pkg::M_STR_H;
          end else begin
            m = pts_pkg::M_IDLE;
            slot_v[3]   = 1'b1;
            slot_tok[3] = pts_pkg::mk_tok(pts_pkg::K_STRING, lo16(org), sp, 1'b0);
            cont = 1'b1;
          end
        end
        default: begin
          m    = pts_pkg::M_IDLE;
          cont = 1'b1;
        end
      endcase

      // start a new token on this byte
      if (cont) begin
        if (pts_pkg::is_space(b)) begin
          m = pts_pkg::M_IDLE;
        end else if (sk[5]) begin
          slot_v[4]   = 1'b1;
          slot_tok[4] = pts_pkg::mk_tok(sk[4:0], lo16(pos_r), 16'd1, 1'b0);
        end else if (b == pts_pkg::CH_LBRACE) begin
          m = pts_pkg::M_BRACE;
        end else if (b == pts_pkg::CH_SLASH || b == pts_pkg::CH_LPAREN ||
                     b == pts_pkg::CH_COLON || b == pts_pkg::CH_DOT ||
                     b == pts_pkg::CH_QUOTE || b == pts_pkg::CH_HASH ||
                     pts_pkg::is_digit(b) || pts_pkg::is_alpha(b)) begin
          org = pos_r;
          sp  = 16'd1;
          if (b == pts_pkg::CH_SLASH) m = pts_pkg::M_SLASH;
          else if (b == pts_pkg::CH_LPAREN) m = pts_pkg::M_LPAR;
          else if (b == pts_pkg::CH_COLON) m = pts_pkg::M_COLON;
          else if (b == pts_pkg::CH_DOT) m = pts_pkg::M_DOT;
          else if (b == pts_pkg::CH_QUOTE) m = pts_pkg::M_STR_Q;
          else if (b == pts_pkg::CH_HASH) m = pts_pkg::M_STR_H;
          else if (pts_pkg::is_digit(b)) begin
            m  = pts_pkg::M_NUM;
            ph = 2'd0;
          end else m = pts_pkg::M_IDENT;
        end else begin
          slot_v[4]   = 1'b1;
          slot_tok[4] = pts_pkg::mk_tok(pts_pkg::K_END, lo16(pos_r), 16'd0, last);
          hlt    = 1'b1;
          closed = last;
          m      = pts_pkg::M_IDLE;
        end
      end
    end

    // stream end: flush the open token, then close
    if (last && !hlt) begin
      if (m == pts_pkg::M_NUM_DOT || m == pts_pkg::M_NUM_E || m == pts_pkg::M_NUM_SIGN) begin
        slot_v[5]   = 1'b1;
        slot_tok[5] = pts_pkg::mk_tok(pts_pkg::K_NUMBER, lo16(org), sp, 1'b0);
        slot_v[6]   = 1'b1;
        if (m == pts_pkg::M_NUM_DOT) begin
          slot_tok[6] = pts_pkg::mk_tok(pts_pkg::K_DOT, lo16(pos_r), 16'd1, 1'b0);
        end else if (m == pts_pkg::M_NUM_E) begin
          slot_tok[6] = pts_pkg::mk_tok(pts_pkg::K_IDENT, lo16(pos_r), 16'd1, 1'b0);
        end else begin
          slot_tok[6] = pts_pkg::mk_tok(pts_pkg::K_IDENT, lo16(pos_r - PB'(1)), 16'd1, 1'b0);
          slot_v[7]   = 1'b1;
          slot_tok[7] = pts_pkg::mk_tok(sg ? pts_pkg::K_MINUS : pts_pkg::K_PLUS,
                                        lo16(pos_r), 16'd1, 1'b0);
        end
      end else if (m == pts_pkg::M_START) begin
        if (cnt != 2'd0) begin
          slot_v[6]   = 1'b1;
          slot_tok[6] = pts_pkg::mk_tok(pts_pkg::K_END, lo16(nextp - PB'(cnt)), 16'd0, 1'b1);
          closed = 1'b1;
        end
      end else if (m == pts_pkg::M_NUM) begin
        slot_v[6]   = 1'b1;
        slot_tok[6] = pts_pkg::mk_tok(pts_pkg::K_NUMBER, lo16(org), sp, 1'b0);
      end else if (m == pts_pkg::M_IDENT) begin
        slot_v[6]   = 1'b1;
        slot_tok[6] = pts_pkg::mk_tok(pts_pkg::K_IDENT, lo16(org), sp, 1'b0);
      end else if (m == pts_pkg::M_STR_Q || m == pts_pkg::M_STR_H ||
                   m == pts_pkg::M_STR_GAP) begin
        slot_v[6]   = 1'b1;
        slot_tok[6] = pts_pkg::mk_tok(pts_pkg::K_STRING, lo16(org), sp, 1'b0);
      end else if (m == pts_pkg::M_COLON) begin
        slot_v[6]   = 1'b1;
        slot_tok[6] = pts_pkg::mk_tok(pts_pkg::K_COLON, lo16(org), 16'd1, 1'b0);
      end else if (m == pts_pkg::M_DOT) begin
        slot_v[6]   = 1'b1;
        slot_tok[6] = pts_pkg::mk_tok(pts_pkg::K_DOT, lo16(org), 16'd1, 1'b0);
      end else if (m == pts_pkg::M_LPAR) begin
        slot_v[6]   = 1'b1;
        slot_tok[6] = pts_pkg::mk_tok(pts_pkg::K_LPAREN, lo16(org), 16'd1, 1'b0);
      end else if (m == pts_pkg::M_SLASH) begin
        slot_v[6]   = 1'b1;
        slot_tok[6] = pts_pkg::mk_tok(pts_pkg::K_SLASH, lo16(org), 16'd1, 1'b0);
      end
    end
    if (last && !closed) begin
      slot_v[8]   = 1'b1;
      slot_tok[8] = pts_pkg::mk_tok(pts_pkg::K_END, lo16(nextp), 16'd0, 1'b1);
    end

    // pack the valid slots in order, keep the first four
    grp = '0;
    n   = 4'd0;
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_v[i]) begin
        if (n < 4'd4) grp.tok[n[1:0]] = slot_tok[i];
        n = n + 4'd1;
      end
    end
    if (n > 4'd4) begin
      grp.tok[3].final_token = 1'b1;
      grp.cnt = 3'd4;
    end else begin
      grp.cnt = n[2:0];
    end

    // next state; a stream end returns to the reset state
    if (last) begin
      mode_nxt   = pts_pkg::M_START;
      pos_nxt    = '0;
      org_nxt    = '0;
      span_nxt   = 16'd0;
      phase_nxt  = 2'd0;
      la_cnt_nxt = 2'd0;
      sign_nxt   = 1'b0;
      halted_nxt = 1'b0;
    end else begin
      mode_nxt   = m;
      pos_nxt    = nextp;
      org_nxt    = org;
      span_nxt   = sp;
      phase_nxt  = ph;
      la_cnt_nxt = cnt;
      sign_nxt   = sg;
      halted_nxt = hlt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= pts_pkg::M_START;
      pos_r    <= '0;
      org_r    <= '0;
      span_r   <= 16'd0;
      phase_r  <= 2'd0;
      la_cnt_r <= 2'd0;
      sign_r   <= 1'b0;
      halted_r <= 1'b0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      org_r    <= org_nxt;
      span_r   <= span_nxt;
      phase_r  <= phase_nxt;
      la_cnt_r <= la_cnt_nxt;
      sign_r   <= sign_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/pts_outq.sv
// Token group queue: holds up to GRP_DEPTH groups and hands out one token per
// transaction. Depends on pts_pkg for group_t and out_item_t.
`default_nettype none
module pts_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire pts_pkg::group_t     push_grp,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pts_pkg::out_item_t       out_item
);

  localparam int unsigned AW = $clog2(pts_pkg::GRP_DEPTH);

  pts_pkg::group_t q_r [pts_pkg::GRP_DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r;
  logic [1:0]      idx_r;
  logic            pop;
  pts_pkg::group_t head;

  assign head      = q_r[rd_ptr_r];
  assign full      = (count_r == (AW+1)'(pts_pkg::GRP_DEPTH));
  assign out_valid = (count_r != '0);
  assign out_item  = head.tok[idx_r];
  assign pop       = out_valid && out_ready && ({1'b0, idx_r} == head.cnt - 3'd1);

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      idx_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
        idx_r    <= 2'd0;
      end else if (out_valid && out_ready) begin
        idx_r <= idx_r + 2'd1;
      end
      if (push && !pop) count_r <= count_r + (AW+1)'(1);
      else if (pop && !push) count_r <= count_r - (AW+1)'(1);
    end
  end

endmodule
`default_nettype wire

// File: design/pascal_token_scanner.sv
// Top level of the Pascal token scanner: input register, scanner step, token queue.
// Depends on pts_pkg, pts_chan_if, pts_scan and pts_outq.
//
// Takes one source byte per transaction and reports Pascal tokens (kind, start
// offset, length) as soon as each token's last byte is known. An input byte is
// captured in an input register and processed from there once the token queue
// has room, so a new byte is accepted every cycle while it has room; the queue
// holds four groups, a group being the zero to four tokens one byte produces.
// The output delivers one token per cycle while the receiver is ready, so the
// tokens of one byte leave in turn. Whitespace, comments and a leading byte-order
// mark give no tokens; the final byte of a stream closes it with an end token.
`default_nettype none
module pascal_token_scanner #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pts_chan_if.sink   in_ch,
  pts_chan_if.source out_ch
);

  logic              stg_v_r;
  pts_pkg::in_item_t stg_r;
  logic              adv, q_full;
  pts_pkg::group_t   grp;
  pts_pkg::out_item_t out_item;

  assign adv         = stg_v_r && !q_full;
  assign in_ch.ready = !stg_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) stg_r <= in_ch.data;
  end

  pts_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(adv),
    .item   (stg_r),
    .grp    (grp)
  );

  // drop groups without tokens
  pts_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (adv && (grp.cnt != 3'd0)),
    .push_grp (grp),
    .full     (q_full),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_item (out_item)
  );

  assign out_ch.data = out_item;

endmodule
`default_nettype wire
